// File: hdl/htc_pkg.sv
// Shared types and constants for the humidity and temperature calibrator.
`timescale 1ns / 1ps
package htc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RH2_W      = 8;
   localparam int DEG8_W     = 10;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int DP_W       = DEG8_W + 1;
   localparam int PROD_W     = 28;
   localparam int HSUM_W     = 30;
   localparam int TSUM_W     = 32;
   localparam int NUM_W      = 32;
   localparam int DIV_W      = 17;
   localparam int STEPS      = 4;
   localparam int DIV_STAGES = NUM_W / STEPS;
   localparam int VALUE_W    = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [NUM_W-1:0]   HUM_MAX    = NUM_W'(100);
   localparam logic [NUM_W-1:0]   TEMP_POS   = NUM_W'(8388607);
   localparam logic [NUM_W-1:0]   TEMP_NEG   = NUM_W'(8388608);
   localparam logic [VALUE_W-1:0] VALUE_MAX  = 24'h7FFFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN  = 24'h800000;

   localparam logic [CSR_ADDR_W-1:0] REG_HUM_OUT_LOW   = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HUM_OUT_HIGH  = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HUM_RH2_LOW   = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_HUM_RH2_HIGH  = 4'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_OUT_LOW  = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_OUT_HIGH = 4'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_DEG_LOW  = 4'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_DEG_HIGH = 4'd7;

   localparam logic CH_HUM  = 1'b0;
   localparam logic CH_TEMP = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] hum_o0;
      logic [SAMPLE_W-1:0] hum_o1;
      logic [RH2_W-1:0]    hum_p0;
      logic [RH2_W-1:0]    hum_p1;
      logic [SAMPLE_W-1:0] temp_o0;
      logic [SAMPLE_W-1:0] temp_o1;
      logic [DEG8_W-1:0]   temp_p0;
      logic [DEG8_W-1:0]   temp_p1;
   } calib_type;

   typedef struct packed {
      logic             ch;
      logic             neg;
      logic             err;
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] qn;
   } div_type;

endpackage

// File: hdl/htc_front.sv
// Front stages: point selection, products, sums and sign normalisation.
`timescale 1ns / 1ps
module htc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  htc_pkg::calib_type              calib,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_ch,
   input  logic [htc_pkg::SAMPLE_W-1:0]    in_raw,
   output logic                            out_valid,
   input  logic                            out_ready,
   output htc_pkg::div_type                out_data
);
   import htc_pkg::*;

   logic [3:0] v_ff;
   logic [3:0] rdy;

   // stage 0
   logic                     ch0_ff, ch0_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in, den0_ff, den0_in;
   logic signed [DP_W-1:0]   dp_ff, dp_in;
   logic [DEG8_W-1:0]        p0_ff, p0_in;
   // stage 1
   logic                     ch1_ff;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic signed [DIFF_W-1:0] den1_ff;
   // stage 2
   logic                     ch2_ff;
   logic signed [HSUM_W-1:0] h_ff, h_in;
   logic signed [TSUM_W-1:0] a_ff, a_in;
   logic signed [DIFF_W-1:0] den2_ff;
   // stage 3
   div_type                  d_ff, d_in;

   assign rdy[3]    = !v_ff[3] || out_ready;
   assign rdy[2]    = !v_ff[2] || rdy[3];
   assign rdy[1]    = !v_ff[1] || rdy[2];
   assign rdy[0]    = !v_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[3];
   assign out_data  = d_ff;

   always_comb begin
      ch0_in = in_ch;
      if (in_ch == CH_HUM) begin
         diff_in = DIFF_W'($signed(in_raw)) - DIFF_W'($signed(calib.hum_o0));
         den0_in = DIFF_W'($signed(calib.hum_o1)) - DIFF_W'($signed(calib.hum_o0));
         dp_in   = $signed(DP_W'(calib.hum_p1)) - $signed(DP_W'(calib.hum_p0));
         p0_in   = DEG8_W'(calib.hum_p0);
      end else begin
         diff_in = DIFF_W'($signed(in_raw)) - DIFF_W'($signed(calib.temp_o0));
         den0_in = DIFF_W'($signed(calib.temp_o1)) - DIFF_W'($signed(calib.temp_o0));
         dp_in   = $signed(DP_W'(calib.temp_p1)) - $signed(DP_W'(calib.temp_p0));
         p0_in   = calib.temp_p0;
      end
   end

   assign prod1_in = PROD_W'(dp_ff) * PROD_W'(diff_ff);
   assign prod2_in = PROD_W'($signed({1'b0, p0_ff})) * PROD_W'(den0_ff);

   assign h_in = HSUM_W'(prod1_ff) + HSUM_W'(prod2_ff) + HSUM_W'(den1_ff);
   assign a_in = (TSUM_W'(prod1_ff) + TSUM_W'(prod2_ff)) <<< 3;

   always_comb begin
      logic                     dneg;
      logic [DIFF_W-1:0]        adu;
      logic signed [HSUM_W-1:0] hn;
      logic signed [TSUM_W-1:0] an;
      logic [TSUM_W-1:0]        mag;
      dneg = den2_ff[DIFF_W-1];
      adu  = dneg ? DIFF_W'(-den2_ff) : DIFF_W'(den2_ff);
      hn   = dneg ? -h_ff : h_ff;
      an   = dneg ? -a_ff : a_ff;
      mag  = an[TSUM_W-1] ? TSUM_W'(-an) : TSUM_W'(an);
      d_in.ch      = ch2_ff;
      d_in.err     = (den2_ff == '0);
      d_in.divisor = {adu[DIFF_W-2:0], 1'b0};
      d_in.rem     = '0;
      if (ch2_ff == CH_HUM) begin
         d_in.neg = hn[HSUM_W-1];
         d_in.qn  = hn[HSUM_W-1] ? '0 : NUM_W'(unsigned'(hn));
      end else begin
         d_in.neg = an[TSUM_W-1];
         d_in.qn  = {mag[NUM_W-2:0], 1'b0} + NUM_W'(adu);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ch0_ff  <= ch0_in;
         diff_ff <= diff_in;
         den0_ff <= den0_in;
         dp_ff   <= dp_in;
         p0_ff   <= p0_in;
      end
      if (rdy[1]) begin
         ch1_ff   <= ch0_ff;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         den1_ff  <= den0_ff;
      end
      if (rdy[2]) begin
         ch2_ff  <= ch1_ff;
         h_ff    <= h_in;
         a_ff    <= a_in;
         den2_ff <= den1_ff;
      end
      if (rdy[3]) begin
         d_ff <= d_in;
      end
   end

endmodule

// File: hdl/htc_div_stage.sv
// One divider stage: several restoring quotient steps and a register.
`timescale 1ns / 1ps
module htc_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  htc_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output htc_pkg::div_type out_data
);
   import htc_pkg::*;

   logic    v_ff;
   div_type d_ff, d_in;

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = d_ff;

   always_comb begin
      logic [DIV_W-1:0] r;
      logic [NUM_W-1:0] q;
      logic [DIV_W:0]   sh;
      r = in_data.rem;
      q = in_data.qn;
      for (int i = 0; i < STEPS; i++) begin
         sh = {r, q[NUM_W-1]};
         q  = {q[NUM_W-2:0], 1'b0};
         if (sh >= {1'b0, in_data.divisor}) begin
            r    = DIV_W'(sh - {1'b0, in_data.divisor});
            q[0] = 1'b1;
         end else begin
            r = sh[DIV_W-1:0];
         end
      end
      d_in     = in_data;
      d_in.rem = r;
      d_in.qn  = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) d_ff <= d_in;
   end

endmodule

// File: hdl/htc_format.sv
// Output stage: clamp, sign and saturate the quotient into the result item.
`timescale 1ns / 1ps
module htc_format (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  htc_pkg::div_type              in_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [htc_pkg::VALUE_W-1:0]   rsp_value,
   output logic                          rsp_channel_echo,
   output logic                          rsp_calib_error
);
   import htc_pkg::*;

   logic               v_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               ch_ff, err_ff;

   assign in_ready         = !v_ff || !rsp_stall;
   assign rsp_valid        = v_ff;
   assign rsp_value        = value_ff;
   assign rsp_channel_echo = ch_ff;
   assign rsp_calib_error  = err_ff;

   always_comb begin
      if (in_data.err) begin
         value_in = '0;
      end else if (in_data.ch == CH_HUM) begin
         if (in_data.neg)              value_in = '0;
         else if (in_data.qn > HUM_MAX) value_in = VALUE_W'(HUM_MAX);
         else                          value_in = in_data.qn[VALUE_W-1:0];
      end else if (in_data.neg) begin
         if (in_data.qn > TEMP_NEG) value_in = VALUE_MIN;
         else                       value_in = VALUE_W'(-in_data.qn);
      end else begin
         if (in_data.qn > TEMP_POS) value_in = VALUE_MAX;
         else                       value_in = in_data.qn[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         value_ff <= value_in;
         ch_ff    <= in_data.ch;
         err_ff   <= in_data.err;
      end
   end

endmodule

// File: hdl/humidity_temperature_calibrator.sv
// Top level: calibration registers, front stages, pipelined divider, output stage.
`timescale 1ns / 1ps
// Two-point linear calibration for humidity and temperature samples. One item
// may enter every cycle while req_stall is low, and each item passes through
// thirteen register stages: four front stages (point selection, two
// multipliers, sums, sign normalisation), eight divider stages retiring four
// quotient bits each, and one output register. A stall only holds stages that
// are full, so bubbles close up.
// Write calibration registers only while no item is in flight.
module humidity_temperature_calibrator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [htc_pkg::SAMPLE_W-1:0]     req_raw_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [htc_pkg::VALUE_W-1:0]      rsp_value,
   output logic                             rsp_channel_echo,
   output logic                             rsp_calib_error,
   input  logic                             csr_write,
   input  logic [htc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [htc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import htc_pkg::*;

   calib_type calib_ff;
   logic      front_ready;

   logic    dv    [DIV_STAGES+1];
   logic    dr    [DIV_STAGES+1];
   div_type dd    [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '{hum_o1: SAMPLE_W'(1), temp_o1: SAMPLE_W'(1), default: '0};
      end else if (csr_write) begin
         case (csr_index)
            REG_HUM_OUT_LOW:   calib_ff.hum_o0  <= csr_wdata;
            REG_HUM_OUT_HIGH:  calib_ff.hum_o1  <= csr_wdata;
            REG_HUM_RH2_LOW:   calib_ff.hum_p0  <= csr_wdata[RH2_W-1:0];
            REG_HUM_RH2_HIGH:  calib_ff.hum_p1  <= csr_wdata[RH2_W-1:0];
            REG_TEMP_OUT_LOW:  calib_ff.temp_o0 <= csr_wdata;
            REG_TEMP_OUT_HIGH: calib_ff.temp_o1 <= csr_wdata;
            REG_TEMP_DEG_LOW:  calib_ff.temp_p0 <= csr_wdata[DEG8_W-1:0];
            REG_TEMP_DEG_HIGH: calib_ff.temp_p1 <= csr_wdata[DEG8_W-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   assign req_stall = !front_ready;

   htc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .calib     (calib_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_ch     (req_cmd),
      .in_raw    (req_raw_sample),
      .out_valid (dv[0]),
      .out_ready (dr[0]),
      .out_data  (dd[0])
   );

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      htc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[g]),
         .in_ready  (dr[g]),
         .in_data   (dd[g]),
         .out_valid (dv[g+1]),
         .out_ready (dr[g+1]),
         .out_data  (dd[g+1])
      );
   end

   htc_format u_format (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (dv[DIV_STAGES]),
      .in_ready         (dr[DIV_STAGES]),
      .in_data          (dd[DIV_STAGES]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_channel_echo (rsp_channel_echo),
      .rsp_calib_error  (rsp_calib_error)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calib_error |-> rsp_value == '0)
      else $error("calibration error with nonzero value");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_echo == CH_HUM |-> rsp_value <= VALUE_W'(HUM_MAX))
      else $error("humidity result out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown straight after reset");

endmodule
